>>> rtl/psg_pkg.sv
`default_nettype none

package psg_pkg;

    localparam int FRACTION_BITS = 16;

    localparam int STEP_W   = 16;
    localparam int TONE_W   = 10;
    localparam int GAIN_W   = 14;
    localparam int PER_W    = 28;
    localparam int CD_W     = 32;
    localparam int ALU_W    = 44;
    localparam int LEFT_W   = FRACTION_BITS + 2;
    localparam int MUL_A_W  = 24;
    localparam int MUL_B_W  = 17;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int SAMPLE_W = 15;
    localparam int LFSR_W   = 17;

    localparam logic [STEP_W-1:0]   STEP_RESET     = 16'd12918;
    localparam logic [PER_W-1:0]    PERIOD_FLOOR   = 28'h00003fe;
    localparam logic [LFSR_W-1:0]   TAPS_WHITE     = 17'h14002;
    localparam logic [LFSR_W-1:0]   TAPS_PERIODIC  = 17'h08000;
    localparam logic [LFSR_W-1:0]   SHIFTER_PRESET = 17'h00f35;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE     = 15'h7fff;

    localparam logic signed [ALU_W-1:0] STEP_SIZE  = ALU_W'(64'd1 << FRACTION_BITS);
    localparam logic signed [ALU_W-1:0] FULL_LIMIT = ALU_W'(64'd32767 << FRACTION_BITS);

    localparam logic [2:0] REG_NOISE = 3'd6;

    typedef struct packed {
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
        logic                    sub;
    } alu_req_t;

    function automatic logic [GAIN_W-1:0] gain_rom(input logic [3:0] idx);
        logic [GAIN_W-1:0] g;
        case (idx)
            4'd0:    g = 14'd10922;
            4'd1:    g = 14'd8878;
            4'd2:    g = 14'd7052;
            4'd3:    g = 14'd5601;
            4'd4:    g = 14'd4449;
            4'd5:    g = 14'd3534;
            4'd6:    g = 14'd2807;
            4'd7:    g = 14'd2230;
            4'd8:    g = 14'd1771;
            4'd9:    g = 14'd1407;
            4'd10:   g = 14'd1117;
            4'd11:   g = 14'd887;
            4'd12:   g = 14'd705;
            4'd13:   g = 14'd560;
            4'd14:   g = 14'd444;
            default: g = 14'd0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

>>> rtl/psg_in_if.sv
`default_nettype none

interface psg_in_if;
    import psg_pkg::*;

    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] write_data;

    modport source (output valid, output operation, output write_data, input ready);
    modport sink (input valid, input operation, input write_data, output ready);
endinterface

`default_nettype wire

>>> rtl/psg_out_if.sv
`default_nettype none

interface psg_out_if;
    import psg_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> rtl/psg_alu.sv
`default_nettype none

module psg_alu (
    input  wire psg_pkg::alu_req_t               req,
    output logic signed [psg_pkg::ALU_W-1:0]     sum,
    output logic                                 not_pos
);
    import psg_pkg::*;

    always_comb
    begin
        if (req.sub)
        begin
            sum = req.a - req.b;
        end
        else
        begin
            sum = req.a + req.b;
        end
        not_pos = (sum <= 0);
    end
endmodule

`default_nettype wire

>>> rtl/psg_mul.sv
`default_nettype none

module psg_mul (
    input  wire logic signed [psg_pkg::MUL_A_W-1:0] a,
    input  wire logic signed [psg_pkg::MUL_B_W-1:0] b,
    output logic signed [psg_pkg::MUL_P_W-1:0]      p
);
    import psg_pkg::*;

    assign p = MUL_P_W'(a) * MUL_P_W'(b);
endmodule

`default_nettype wire

>>> rtl/psg_three_tone_noise_sound_generator.sv
`default_nettype none

// Three square-wave tones and one noise source with a 2 dB volume table. A byte
// write passes through ST_WREG, and also through ST_WPER when it sets a tone
// period. A tick runs a sequencer over the four channels with one shared adder and
// one multiplier: the silent-channel check over all four channels; for each tone,
// the start of its countdown and an edge loop that repeats for each pair of edges
// in one sample; for the noise channel, one pass per event, with an extra step
// when the shift register steps; after each channel, the mix multiply and
// accumulate; and at the end, the presentation of the sample.
// The input is not ready while an item is worked on; a finished sample waits in
// the output register and a tick only stalls at its end if it is still untaken.
// A cfg_we write of the step takes effect at the next period or noise mode write.
module psg_three_tone_noise_sound_generator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [psg_pkg::STEP_W-1:0]  cfg_wdata,
    psg_in_if.sink                           in_ch,
    psg_out_if.source                        out_ch
);
    import psg_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_WREG, ST_WPER, ST_SIL,
        ST_TN_A, ST_TN_B, ST_TN_C, ST_TN_D, ST_TN_F, ST_TN_G, ST_TN_E,
        ST_NZ_A, ST_NZ_B, ST_NZ_C, ST_NZ_D, ST_NZ_E, ST_NZ_F, ST_NZ_G, ST_NZ_H,
        ST_MX_MUL, ST_MX_ACC, ST_DONE
    } state_t;

    state_t                    state_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [7:0]                dat_reg;
    logic [2:0]                latched_reg;
    logic [TONE_W-1:0]         tone_reg [3];
    logic [1:0]                mode_reg;
    logic [TONE_W-1:0]         tval_reg;
    logic [1:0]                tgt_reg;
    logic [GAIN_W-1:0]         gain_reg [4];
    logic [PER_W-1:0]          per_reg [4];
    logic signed [CD_W-1:0]    cd_reg [4];
    logic [3:0]                lvl_reg;
    logic [LFSR_W-1:0]         lfsr_reg;
    logic [LFSR_W-1:0]         taps_reg;
    logic [1:0]                ch_reg;
    logic signed [ALU_W-1:0]   area_reg;
    logic signed [ALU_W-1:0]   total_reg;
    logic signed [ALU_W-1:0]   prod_reg;
    logic signed [LEFT_W-1:0]  left_reg;
    logic signed [LEFT_W-1:0]  ev_reg;
    logic                      out_valid_reg;
    logic [SAMPLE_W-1:0]       sample_reg;

    alu_req_t                  alu_req;
    logic signed [ALU_W-1:0]   alu_sum;
    logic                      alu_not_pos;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic signed [ALU_W-1:0]   cd_ext;
    logic signed [ALU_W-1:0]   per_ext;
    logic signed [ALU_W-1:0]   ev_ext;
    logic signed [ALU_W-1:0]   left_ext;
    logic [PER_W-1:0]          new_per;
    logic [PER_W-1:0]          noise_per;
    logic [LFSR_W-1:0]         lfsr_next;
    logic [2:0]                wr_idx;
    logic [1:0]                wr_chan;

    assign cd_ext   = ALU_W'(cd_reg[ch_reg]);
    assign per_ext  = ALU_W'({1'b0, per_reg[ch_reg]});
    assign ev_ext   = ALU_W'(ev_reg);
    assign left_ext = ALU_W'(left_reg);
    assign wr_idx   = dat_reg[7] ? dat_reg[6:4] : latched_reg;
    assign wr_chan  = wr_idx[2:1];

    assign lfsr_next = lfsr_reg[0] ? ((lfsr_reg ^ taps_reg) >> 1) : (lfsr_reg >> 1);

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.sample = sample_reg;

    // shared adder operand select
    always_comb
    begin
        alu_req = '{a: cd_ext, b: STEP_SIZE, sub: 1'b0};
        unique case (state_reg)
            ST_SIL:              alu_req = '{a: cd_ext, b: STEP_SIZE, sub: 1'b0};
            ST_TN_B:             alu_req = '{a: cd_ext, b: STEP_SIZE, sub: 1'b1};
            ST_TN_C, ST_TN_D,
            ST_NZ_E:             alu_req = '{a: cd_ext, b: per_ext, sub: 1'b0};
            ST_TN_F, ST_TN_G,
            ST_NZ_F:             alu_req = '{a: area_reg, b: per_ext, sub: 1'b0};
            ST_TN_E, ST_NZ_G:    alu_req = '{a: area_reg, b: cd_ext, sub: 1'b1};
            ST_NZ_B:             alu_req = '{a: area_reg, b: cd_ext, sub: 1'b0};
            ST_NZ_C:             alu_req = '{a: cd_ext, b: ev_ext, sub: 1'b1};
            ST_NZ_H:             alu_req = '{a: left_ext, b: ev_ext, sub: 1'b1};
            ST_MX_ACC:           alu_req = '{a: total_reg, b: prod_reg, sub: 1'b0};
            default:             alu_req = '{a: cd_ext, b: STEP_SIZE, sub: 1'b0};
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_WPER)
        begin
            mul_a = MUL_A_W'({1'b0, step_reg});
            mul_b = MUL_B_W'({1'b0, tval_reg});
        end
        else
        begin
            mul_a = MUL_A_W'(area_reg[LEFT_W-1:0]);
            mul_b = MUL_B_W'({1'b0, gain_reg[ch_reg]});
        end
    end

    always_comb
    begin
        new_per = mul_p[PER_W-1:0];
        if (new_per == '0)
        begin
            new_per = PERIOD_FLOOR;
        end
        if (dat_reg[1:0] == 2'd3)
        begin
            noise_per = {per_reg[2][PER_W-2:0], 1'b0};
        end
        else
        begin
            noise_per = PER_W'({12'd0, step_reg}) << (5 + {1'b0, dat_reg[1:0]});
        end
        if (noise_per == '0)
        begin
            noise_per = PERIOD_FLOOR;
        end
    end

    psg_alu u_alu (
        .req     (alu_req),
        .sum     (alu_sum),
        .not_pos (alu_not_pos)
    );

    psg_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_RESET;
            latched_reg   <= '0;
            mode_reg      <= '0;
            for (int i = 0; i < 3; i++)
            begin
                tone_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                gain_reg[i] <= '0;
                per_reg[i]  <= PER_W'(STEP_RESET);
                cd_reg[i]   <= CD_W'(STEP_RESET);
            end
            lvl_reg       <= {SHIFTER_PRESET[0], 3'b000};
            lfsr_reg      <= SHIFTER_PRESET;
            taps_reg      <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        dat_reg   <= in_ch.write_data;
                        ch_reg    <= '0;
                        total_reg <= '0;
                        state_reg <= in_ch.operation ? ST_SIL : ST_WREG;
                    end
                end
                ST_WREG:
                begin
                    state_reg <= ST_IDLE;
                    if (dat_reg[7])
                    begin
                        latched_reg <= wr_idx;
                        if (wr_idx == REG_NOISE)
                        begin
                            mode_reg   <= dat_reg[1:0];
                            taps_reg   <= dat_reg[2] ? TAPS_WHITE : TAPS_PERIODIC;
                            per_reg[3] <= noise_per;
                        end
                        else if (wr_idx[0])
                        begin
                            gain_reg[wr_chan] <= gain_rom(dat_reg[3:0]);
                        end
                        else
                        begin
                            tone_reg[wr_chan][3:0] <= dat_reg[3:0];
                            tval_reg  <= {tone_reg[wr_chan][TONE_W-1:4], dat_reg[3:0]};
                            tgt_reg   <= wr_chan;
                            state_reg <= ST_WPER;
                        end
                    end
                    else if (!wr_idx[0] && wr_idx != REG_NOISE)
                    begin
                        tone_reg[wr_chan][TONE_W-1:4] <= dat_reg[5:0];
                        tval_reg  <= {dat_reg[5:0], tone_reg[wr_chan][3:0]};
                        tgt_reg   <= wr_chan;
                        state_reg <= ST_WPER;
                    end
                end
                ST_WPER:
                begin
                    per_reg[tgt_reg] <= new_per;
                    if (tgt_reg == 2'd2 && mode_reg == 2'd3)
                    begin
                        per_reg[3] <= {new_per[PER_W-2:0], 1'b0};
                    end
                    state_reg <= ST_IDLE;
                end
                ST_SIL:
                begin
                    if (gain_reg[ch_reg] == '0 && cd_ext <= STEP_SIZE)
                    begin
                        cd_reg[ch_reg] <= alu_sum[CD_W-1:0];
                    end
                    ch_reg <= ch_reg + 2'd1;
                    if (ch_reg == 2'd3)
                    begin
                        state_reg <= ST_TN_A;
                    end
                end
                ST_TN_A:
                begin
                    area_reg  <= lvl_reg[ch_reg] ? cd_ext : '0;
                    state_reg <= ST_TN_B;
                end
                ST_TN_B:
                begin
                    cd_reg[ch_reg] <= alu_sum[CD_W-1:0];
                    state_reg      <= ST_TN_C;
                end
                ST_TN_C:
                begin
                    if (cd_ext <= 0)
                    begin
                        cd_reg[ch_reg] <= alu_sum[CD_W-1:0];
                        state_reg      <= ST_TN_D;
                    end
                    else
                    begin
                        state_reg <= ST_TN_E;
                    end
                end
                ST_TN_D:
                begin
                    if (cd_ext > 0)
                    begin
                        lvl_reg[ch_reg] <= !lvl_reg[ch_reg];
                        state_reg       <= lvl_reg[ch_reg] ? ST_TN_E : ST_TN_F;
                    end
                    else
                    begin
                        cd_reg[ch_reg] <= alu_sum[CD_W-1:0];
                        state_reg      <= ST_TN_G;
                    end
                end
                ST_TN_G:
                begin
                    area_reg  <= alu_sum;
                    state_reg <= ST_TN_C;
                end
                ST_TN_F:
                begin
                    area_reg  <= alu_sum;
                    state_reg <= ST_TN_E;
                end
                ST_TN_E:
                begin
                    if (lvl_reg[ch_reg])
                    begin
                        area_reg <= alu_sum;
                    end
                    state_reg <= ST_MX_MUL;
                end
                ST_NZ_A:
                begin
                    area_reg  <= '0;
                    left_reg  <= LEFT_W'(STEP_SIZE);
                    state_reg <= ST_NZ_B;
                end
                ST_NZ_B:
                begin
                    if (cd_ext > 0 && cd_ext < left_ext)
                    begin
                        ev_reg <= cd_reg[ch_reg][LEFT_W-1:0];
                    end
                    else
                    begin
                        ev_reg <= left_reg;
                    end
                    if (lvl_reg[ch_reg])
                    begin
                        area_reg <= alu_sum;
                    end
                    state_reg <= ST_NZ_C;
                end
                ST_NZ_C:
                begin
                    cd_reg[ch_reg] <= alu_sum[CD_W-1:0];
                    state_reg      <= ST_NZ_D;
                end
                ST_NZ_D:
                begin
                    if (cd_ext <= 0)
                    begin
                        lfsr_reg        <= lfsr_next;
                        lvl_reg[ch_reg] <= lfsr_next[0];
                        state_reg       <= ST_NZ_E;
                    end
                    else
                    begin
                        state_reg <= ST_NZ_G;
                    end
                end
                ST_NZ_E:
                begin
                    cd_reg[ch_reg] <= alu_sum[CD_W-1:0];
                    state_reg      <= lvl_reg[ch_reg] ? ST_NZ_F : ST_NZ_G;
                end
                ST_NZ_F:
                begin
                    area_reg  <= alu_sum;
                    state_reg <= ST_NZ_G;
                end
                ST_NZ_G:
                begin
                    if (lvl_reg[ch_reg])
                    begin
                        area_reg <= alu_sum;
                    end
                    state_reg <= ST_NZ_H;
                end
                ST_NZ_H:
                begin
                    left_reg  <= alu_sum[LEFT_W-1:0];
                    state_reg <= alu_not_pos ? ST_MX_MUL : ST_NZ_B;
                end
                ST_MX_MUL:
                begin
                    prod_reg  <= ALU_W'(mul_p);
                    state_reg <= ST_MX_ACC;
                end
                ST_MX_ACC:
                begin
                    total_reg <= alu_sum;
                    ch_reg    <= ch_reg + 2'd1;
                    if (ch_reg == 2'd3)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else if (ch_reg == 2'd2)
                    begin
                        state_reg <= ST_NZ_A;
                    end
                    else
                    begin
                        state_reg <= ST_TN_A;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        if (total_reg < 0 || total_reg > FULL_LIMIT)
                        begin
                            sample_reg <= FULL_SCALE;
                        end
                        else
                        begin
                            sample_reg <= total_reg[FRACTION_BITS +: SAMPLE_W];
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // a transfer in always starts a sequence
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start");

    // tone leaves its edge loop with a positive countdown
    a_tone_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TN_E) |-> (cd_reg[ch_reg] > 0))
        else $error("tone countdown not positive at exit");

    // periods never stall a channel
    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (per_reg[ch_reg] != '0))
        else $error("zero channel period");

    // a sample is only presented after the mix finished
    a_sample_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("sample not from mix");

endmodule

`default_nettype wire

>>> test/psg_tb_scoreboard.sv
`timescale 1ns / 100ps

class psg_scoreboard;
    int unsigned        errors;
    bit [14:0]          sample_q[$];
    int unsigned        step_reg;
    int unsigned        regs[8];
    int unsigned        latch_idx;
    longint             gain[4];
    longint             period[4];
    longint             countdown[4];
    bit                 level[4];
    bit [16:0]          shifter;
    bit [16:0]          taps;
    longint             vol_table[16];

    function new();
        errors = 0;
        step_reg = 12918;
        latch_idx = 0;
        for (int i = 0; i < 8; i++)
        begin
            regs[i] = (i % 2) ? 15 : 0;
        end
        for (int i = 0; i < 4; i++)
        begin
            gain[i] = 0;
            period[i] = 12918;
            countdown[i] = 12918;
            level[i] = 0;
        end
        shifter = 17'h00f35;
        level[3] = shifter[0];
        taps = 0;
        build_volumes();
    endfunction

    function longint unsigned fix_mul_div(longint unsigned x, longint unsigned m,
                                          longint unsigned d);
        longint unsigned hi, lo, t, q, r;
        hi = x >> 32;
        lo = x & 64'hffffffff;
        t = hi * m;
        q = t / d;
        r = t % d;
        return (q << 32) + ((r << 32) + lo * m) / d;
    endfunction

    function void build_volumes();
        longint unsigned top, v;
        top = (64'd32767 << 32) / 3;
        v = fix_mul_div(top, 1023292992, 1000000000);
        for (int i = 0; i < 15; i++)
        begin
            vol_table[i] = (v > top) ? 10922 : longint'(v >> 32);
            v = fix_mul_div(v, 1000000000, 1258925412);
        end
        vol_table[15] = 0;
    endfunction

    function void set_step(int unsigned v);
        step_reg = v & 16'hffff;
    endfunction

    function void tone_period(int unsigned r);
        longint p;
        p = longint'(step_reg) * longint'(regs[r]);
        if (p == 0)
            p = 1022;
        period[r >> 1] = p;
        if (r == 4 && (regs[6] & 3) == 3)
            period[3] = 2 * period[2];
    endfunction

    function void noise_mode();
        int unsigned n;
        longint p;
        n = regs[6];
        taps = (n & 4) ? 17'h14002 : 17'h08000;
        n = n & 3;
        if (n == 3)
            p = 2 * period[2];
        else
            p = longint'(step_reg) << (5 + n);
        if (p == 0)
            p = 1022;
        period[3] = p;
    endfunction

    function void byte_write(bit [7:0] d);
        int unsigned r;
        if (d[7])
        begin
            r = d[6:4];
            latch_idx = r;
            regs[r] = (regs[r] & 10'h3f0) | d[3:0];
            if (r == 6)
                noise_mode();
            else if (r & 1)
                gain[r >> 1] = vol_table[d[3:0]];
            else
                tone_period(r);
        end
        else
        begin
            r = latch_idx;
            if (r == 0 || r == 2 || r == 4)
            begin
                regs[r] = (regs[r] & 4'hf) | (int'(d[5:0]) << 4);
                tone_period(r);
            end
        end
    endfunction

    function bit [14:0] mix_sample();
        longint area[4];
        longint left, ev, total;
        for (int i = 0; i < 4; i++)
        begin
            area[i] = 0;
            if (gain[i] == 0 && countdown[i] <= 65536)
                countdown[i] += 65536;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (level[i])
                area[i] += countdown[i];
            countdown[i] -= 65536;
            while (countdown[i] <= 0)
            begin
                countdown[i] += period[i];
                if (countdown[i] > 0)
                begin
                    level[i] = !level[i];
                    if (level[i])
                        area[i] += period[i];
                    break;
                end
                countdown[i] += period[i];
                area[i] += period[i];
            end
            if (level[i])
                area[i] -= countdown[i];
        end
        left = 65536;
        do
        begin
            ev = (countdown[3] < left) ? countdown[3] : left;
            if (ev <= 0)
                ev = left;
            if (level[3])
                area[3] += countdown[3];
            countdown[3] -= ev;
            if (countdown[3] <= 0)
            begin
                if (shifter[0])
                    shifter = shifter ^ taps;
                shifter = shifter >> 1;
                level[3] = shifter[0];
                countdown[3] += period[3];
                if (level[3])
                    area[3] += period[3];
            end
            if (level[3])
                area[3] -= countdown[3];
            left -= ev;
        end
        while (left > 0);
        total = 0;
        for (int i = 0; i < 4; i++)
        begin
            total += area[i] * gain[i];
        end
        if (total < 0 || total > 64'd32767 * 65536)
            return 15'h7fff;
        return 15'(total / 65536);
    endfunction

    function void note_input(bit op, bit [7:0] d);
        if (op)
            sample_q.push_back(mix_sample());
        else
            byte_write(d);
    endfunction

    function void check_sample(bit [14:0] actual);
        bit [14:0] exp_s;
        if (sample_q.size() == 0)
        begin
            $error("sample: unexpected transfer, actual %0d", actual);
            errors++;
            return;
        end
        exp_s = sample_q.pop_front();
        if (exp_s !== actual)
        begin
            $error("sample: expected %0d actual %0d", exp_s, actual);
            errors++;
        end
    endfunction

    function int pending();
        return sample_q.size();
    endfunction
endclass

>>> test/psg_three_tone_noise_sound_generator_tb.sv
`timescale 1ns / 100ps

module psg_three_tone_noise_sound_generator_tb;
    import psg_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [STEP_W-1:0]  cfg_wdata;
    bit                 idle_on;
    int                 stall_left;
    psg_scoreboard      sb;

    psg_in_if  in_ch();
    psg_out_if out_ch();

    psg_three_tone_noise_sound_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_sample(out_ch.sample);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    task automatic send_item(bit op, bit [7:0] d);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.operation <= op;
        in_ch.write_data <= d;
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_input(op, d);
    endtask

    task automatic write_step(bit [STEP_W-1:0] v);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_step(v);
    endtask

    task automatic random_items(int n);
        bit [7:0] d;
        for (int i = 0; i < n; i++)
        begin
            d = 8'($urandom);
            if ($urandom_range(0, 99) < 40)
                send_item(1'b1, d);
            else
                send_item(1'b0, d);
        end
    endtask

    // tiny step: keep tone periods near the floor so ticks stay short
    task automatic low_step_items(int n);
        bit [2:0] r;
        for (int i = 0; i < 3; i++)
        begin
            send_item(1'b0, {1'b1, 3'(2 * i), 4'($urandom)});
            send_item(1'b0, {1'b0, 1'($urandom), 6'h3f});
        end
        for (int i = 0; i < n; i++)
        begin
            r = 3'(2 * $urandom_range(0, 2));
            case ($urandom_range(0, 2))
                0: send_item(1'b1, 8'($urandom));
                1: send_item(1'b0, {1'b1, 3'(2 * $urandom_range(0, 3) + 1), 4'($urandom)});
                default:
                begin
                    send_item(1'b0, {1'b1, r, 4'($urandom)});
                    send_item(1'b0, {1'b0, 1'($urandom), 6'h3f});
                end
            endcase
        end
    endtask

    initial
    begin
        byte unsigned directed[$];
        sb = new();
        idle_on = 1'b1;
        stall_left = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.operation = 1'b0;
        in_ch.write_data = '0;
        out_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (5) @(posedge clk);
        write_step(16'd12918);

        // 8'h01 marks a tick in this list
        directed = '{8'h90, 8'h8f, 8'h3f, 8'h01, 8'ha0, 8'hb0, 8'h01, 8'he4, 8'hf0,
                     8'h01, 8'he3, 8'h15, 8'h01, 8'hd5, 8'hc1, 8'h00, 8'h01, 8'he0,
                     8'he1, 8'he2, 8'he5, 8'he6, 8'he7, 8'h01, 8'h9f, 8'h01};
        foreach (directed[i])
        begin
            if (directed[i] == 8'h01)
                send_item(1'b1, 8'hff);
            else
                send_item(1'b0, directed[i]);
        end

        random_items(300);
        write_step(16'hffff);
        random_items(250);
        write_step(16'd1);
        low_step_items(60);
        write_step(16'd1024);
        random_items(250);
        write_step(16'($urandom_range(1024, 65535)));
        random_items(250);
        write_step(16'd12918);
        idle_on = 1'b0;
        random_items(250);

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
